// ===== hdl/page_label_char_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Page label generator assertion macros
// Shared forms for the concurrent checks of the page label generator.
// ----------------------------------------------------------------------------
`ifndef PAGE_LABEL_CHAR_GENERATOR_MACROS_SVH
`define PAGE_LABEL_CHAR_GENERATOR_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define PLCG_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page label generator: check failed");

// Next-cycle implication under a synchronous reset.
`define PLCG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page label generator: check failed");

`endif

// ===== hdl/plcg_pkg.sv =====
// ----------------------------------------------------------------------------
// plcg_pkg
// Types, constants, microprogram and numeral tables of the page label generator.
// ----------------------------------------------------------------------------
package plcg_pkg;

   localparam int MAX_LETTER_REPEATS = 64;

   // Label styles
   localparam logic [2:0] STYLE_DEC    = 3'd0;
   localparam logic [2:0] STYLE_LROMAN = 3'd1;
   localparam logic [2:0] STYLE_UROMAN = 3'd2;
   localparam logic [2:0] STYLE_LLET   = 3'd3;
   localparam logic [2:0] STYLE_ULET   = 3'd4;

   // Label status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ROMAN_OOR = 2'd1;
   localparam logic [1:0] ST_LET_LONG  = 2'd2;
   localparam logic [1:0] ST_PAGE_OOR  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_STYLE = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   // Arithmetic constants
   localparam logic [16:0] ROMAN_MAX  = 17'd3999;
   localparam logic [16:0] DIV10_MUL  = 17'd104858;  // ceil(2^20 / 10)
   localparam logic [16:0] DIV26_MUL  = 17'd80660;   // ceil(2^21 / 26)
   localparam logic [6:0]  CHAR_ZERO  = 7'h30;
   localparam logic [6:0]  CHAR_LOW_A = 7'h61;
   localparam logic [6:0]  CHAR_UP_A  = 7'h41;
   localparam logic [6:0]  CASE_BIT   = 7'h20;

   typedef logic [3:0] step_type;

   localparam step_type S_IDLE    = 4'd0;
   localparam step_type S_LOAD    = 4'd1;
   localparam step_type S_STYLE_R = 4'd2;
   localparam step_type S_STYLE_L = 4'd3;
   localparam step_type S_DDIV    = 4'd4;
   localparam step_type S_DEMIT   = 4'd5;
   localparam step_type S_RCHK    = 4'd6;
   localparam step_type S_RSCAN   = 4'd7;
   localparam step_type S_LDEC    = 4'd8;
   localparam step_type S_LMUL    = 4'd9;
   localparam step_type S_LCHK    = 4'd10;
   localparam step_type S_LEMIT   = 4'd11;
   localparam step_type S_EMPTY   = 4'd12;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOAD,
      OP_DDIV,
      OP_DEMIT,
      OP_RCHK,
      OP_RSCAN,
      OP_LDEC,
      OP_LMUL,
      OP_LCHK,
      OP_LEMIT,
      OP_EMPTY
   } op_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_BAD,
      COND_ROMAN,
      COND_LETTER,
      COND_QNZ,
      COND_DLAST,
      COND_RBIG,
      COND_RLAST,
      COND_LLONG,
      COND_LLAST
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jt;
      step_type jf;
   } uword_type;

   // Datapath conditions seen by the sequencer
   typedef struct packed {
      logic bad;
      logic roman;
      logic letter;
      logic qnz;
      logic dlast;
      logic rbig;
      logic rlast;
      logic llong;
      logic llast;
   } flags_type;

   // Sequencer outputs driving the datapath
   typedef struct packed {
      op_type   op;
      step_type step;
   } ctrl_type;

   function automatic uword_type program_word(input step_type step);
      uword_type w;
      case (step)
         S_IDLE:    w = '{OP_ACCEPT, COND_ALWAYS, S_LOAD,    S_LOAD};
         S_LOAD:    w = '{OP_LOAD,   COND_BAD,    S_EMPTY,   S_STYLE_R};
         S_STYLE_R: w = '{OP_NOP,    COND_ROMAN,  S_RCHK,    S_STYLE_L};
         S_STYLE_L: w = '{OP_NOP,    COND_LETTER, S_LDEC,    S_DDIV};
         S_DDIV:    w = '{OP_DDIV,   COND_QNZ,    S_DDIV,    S_DEMIT};
         S_DEMIT:   w = '{OP_DEMIT,  COND_DLAST,  S_IDLE,    S_DEMIT};
         S_RCHK:    w = '{OP_RCHK,   COND_RBIG,   S_EMPTY,   S_RSCAN};
         S_RSCAN:   w = '{OP_RSCAN,  COND_RLAST,  S_IDLE,    S_RSCAN};
         S_LDEC:    w = '{OP_LDEC,   COND_ALWAYS, S_LMUL,    S_LMUL};
         S_LMUL:    w = '{OP_LMUL,   COND_ALWAYS, S_LCHK,    S_LCHK};
         S_LCHK:    w = '{OP_LCHK,   COND_LLONG,  S_EMPTY,   S_LEMIT};
         S_LEMIT:   w = '{OP_LEMIT,  COND_LLAST,  S_IDLE,    S_LEMIT};
         S_EMPTY:   w = '{OP_EMPTY,  COND_ALWAYS, S_IDLE,    S_IDLE};
         default:   w = '{OP_NOP,    COND_ALWAYS, S_IDLE,    S_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [9:0] roman_value(input logic [3:0] idx);
      logic [9:0] v;
      case (idx)
         4'd0:    v = 10'd1000;
         4'd1:    v = 10'd900;
         4'd2:    v = 10'd500;
         4'd3:    v = 10'd400;
         4'd4:    v = 10'd100;
         4'd5:    v = 10'd90;
         4'd6:    v = 10'd50;
         4'd7:    v = 10'd40;
         4'd8:    v = 10'd10;
         4'd9:    v = 10'd9;
         4'd10:   v = 10'd5;
         4'd11:   v = 10'd4;
         4'd12:   v = 10'd1;
         default: v = 10'd1;
      endcase
      return v;
   endfunction

   // First symbol character, upper case
   function automatic logic [6:0] roman_sym1(input logic [3:0] idx);
      logic [6:0] c;
      case (idx)
         4'd0, 4'd1:   c = 7'h4D; // M, C of CM
         4'd2:         c = 7'h44; // D
         4'd3, 4'd4:   c = 7'h43; // C
         4'd5:         c = 7'h58; // X of XC
         4'd6:         c = 7'h4C; // L
         4'd7, 4'd8:   c = 7'h58; // X
         4'd9:         c = 7'h49; // I of IX
         4'd10:        c = 7'h56; // V
         4'd11, 4'd12: c = 7'h49; // I
         default:      c = 7'h49;
      endcase
      if (idx == 4'd1) begin
         c = 7'h43;
      end
      return c;
   endfunction

   // Second symbol character, zero for single-letter symbols
   function automatic logic [6:0] roman_sym2(input logic [3:0] idx);
      logic [6:0] c;
      case (idx)
         4'd1:    c = 7'h4D; // CM
         4'd3:    c = 7'h44; // CD
         4'd5:    c = 7'h43; // XC
         4'd7:    c = 7'h4C; // XL
         4'd9:    c = 7'h58; // IX
         4'd11:   c = 7'h56; // IV
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/plcg_seq.sv =====
// ----------------------------------------------------------------------------
// plcg_seq
// Microprogram sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module plcg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                hold,
   input  plcg_pkg::flags_type flags,
   output plcg_pkg::ctrl_type  ctrl
);

   plcg_pkg::step_type  step_ff;
   plcg_pkg::step_type  step_in;
   plcg_pkg::uword_type word;
   logic                take;

   assign word = plcg_pkg::program_word(step_ff);

   always_comb begin
      case (word.cond)
         plcg_pkg::COND_ALWAYS: take = 1'b1;
         plcg_pkg::COND_BAD:    take = flags.bad;
         plcg_pkg::COND_ROMAN:  take = flags.roman;
         plcg_pkg::COND_LETTER: take = flags.letter;
         plcg_pkg::COND_QNZ:    take = flags.qnz;
         plcg_pkg::COND_DLAST:  take = flags.dlast;
         plcg_pkg::COND_RBIG:   take = flags.rbig;
         plcg_pkg::COND_RLAST:  take = flags.rlast;
         plcg_pkg::COND_LLONG:  take = flags.llong;
         plcg_pkg::COND_LLAST:  take = flags.llast;
         default:               take = 1'b1;
      endcase
      // hold the step while the datapath waits on a handshake
      if (hold) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = word.jt;
      end else begin
         step_in = word.jf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= plcg_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.step = step_ff;

endmodule

// ===== hdl/page_label_char_generator.sv =====
// ----------------------------------------------------------------------------
// page_label_char_generator
// Turns a page offset into its page label, one ASCII character per beat.
// ----------------------------------------------------------------------------
// The block takes one page offset at a time and returns that page's label as
// a run of result beats, one character each, last_char marking the final beat.
// The label value is start_value + page_offset; styles are decimal, lower or
// upper roman (1..3999) and lower or upper repeated letters (at most 64
// repeats). An offset at or beyond page_count, a zero start value, a roman
// value above 3999 or too many letter repeats give a single beat with
// char_code 0 and the reason in label_status. A short microprogram steps
// through each item, one step per cycle unless a missing offset or a full
// output register holds it, with one character leaving per emitting step;
// the step counter is the only pacing element. A decimal label has at most 6
// digits and a roman label at most 15 characters. The next offset is taken
// when the sequencer is back at its idle step; a finished beat waits in the
// output register while the sequencer goes on. Configuration sits behind an
// APB-style port: start_value at 0x0, label_style at 0x4, page_count at 0x8.
// ----------------------------------------------------------------------------
`include "page_label_char_generator_macros.svh"

module page_label_char_generator (
   input  logic        clock,
   input  logic        reset,
   // offset channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_page_offset,
   // label character channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last_char,
   output logic [1:0]  rsp_label_status,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] start_ff;
   logic [2:0]  style_ff;
   logic [15:0] count_ff;
   logic        cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 16'd1;
         style_ff <= plcg_pkg::STYLE_DEC;
         count_ff <= 16'd0;
      end else if (cfg_write) begin
         case (paddr[3:2])
            plcg_pkg::REG_START: start_ff <= pwdata[15:0];
            plcg_pkg::REG_STYLE: style_ff <= pwdata[2:0];
            plcg_pkg::REG_COUNT: count_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         plcg_pkg::REG_START: prdata = {16'd0, start_ff};
         plcg_pkg::REG_STYLE: prdata = {29'd0, style_ff};
         plcg_pkg::REG_COUNT: prdata = {16'd0, count_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   plcg_pkg::ctrl_type  ctrl;
   plcg_pkg::flags_type flags;
   logic                hold;

   plcg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .hold  (hold),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   logic [15:0] off_ff;       // accepted offset
   logic [16:0] v_ff;         // label value, later the running remainder
   logic [1:0]  st_ff;        // status for an empty label
   logic [2:0]  dcnt_ff;      // decimal digits stacked
   logic [3:0]  dstack_ff [0:5];
   logic [3:0]  ri_ff;        // roman numeral table index
   logic        phase_ff;     // second character of a two-letter symbol
   logic [12:0] rep_ff;       // letter repeats still to send after this one
   logic [4:0]  letter_ff;

   logic        rsp_valid_ff;
   logic [6:0]  rsp_char_ff;
   logic        rsp_last_ff;
   logic [1:0]  rsp_status_ff;

   // Output register is free when empty or being drained this cycle
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Decimal: one divide by ten per step via reciprocal multiply
   // ---------------------------------------------------------------------
   logic [33:0] prod10;
   logic [16:0] dq;
   logic [16:0] dq10;
   logic [16:0] drem;
   logic [2:0]  dtop;

   assign prod10 = 34'(v_ff) * 34'(plcg_pkg::DIV10_MUL);
   assign dq     = {3'b000, prod10[33:20]};
   assign dq10   = {dq[13:0], 3'b000} + {dq[15:0], 1'b0};
   assign drem   = v_ff - dq10;
   assign dtop   = dcnt_ff - 3'd1;

   // ---------------------------------------------------------------------
   // Roman: scan the numeral table, at most one symbol character per step
   // ---------------------------------------------------------------------
   logic [16:0] rval;
   logic [6:0]  rsym1;
   logic [6:0]  rsym2;
   logic        rtwo;
   logic        rge;
   logic        rsub;
   logic [6:0]  rchar;

   assign rval  = {7'd0, plcg_pkg::roman_value(ri_ff)};
   assign rsym1 = plcg_pkg::roman_sym1(ri_ff);
   assign rsym2 = plcg_pkg::roman_sym2(ri_ff);
   assign rtwo  = (rsym2 != 7'd0);
   assign rge   = (v_ff >= rval);
   assign rsub  = rge && (!rtwo || phase_ff);

   always_comb begin
      rchar = phase_ff ? rsym2 : rsym1;
      if (style_ff == plcg_pkg::STYLE_LROMAN) begin
         rchar = rchar | plcg_pkg::CASE_BIT;
      end
   end

   // ---------------------------------------------------------------------
   // Letters: (value-1)/26 by reciprocal multiply, remainder in next step
   // ---------------------------------------------------------------------
   logic [33:0] prod26;
   logic [16:0] t26;
   logic [16:0] lrem;
   logic [6:0]  lbase;

   assign prod26 = 34'(v_ff) * 34'(plcg_pkg::DIV26_MUL);
   assign t26    = {rep_ff, 4'b0000} + {1'b0, rep_ff, 3'b000} + {3'b000, rep_ff, 1'b0};
   assign lrem   = v_ff - t26;
   assign lbase  = (style_ff == plcg_pkg::STYLE_LLET) ? plcg_pkg::CHAR_LOW_A
                                                      : plcg_pkg::CHAR_UP_A;

   // ---------------------------------------------------------------------
   // Jump conditions
   // ---------------------------------------------------------------------
   assign flags.bad    = (off_ff >= count_ff) || (start_ff == 16'd0);
   assign flags.roman  = (style_ff == plcg_pkg::STYLE_LROMAN) ||
                         (style_ff == plcg_pkg::STYLE_UROMAN);
   assign flags.letter = (style_ff == plcg_pkg::STYLE_LLET) ||
                         (style_ff == plcg_pkg::STYLE_ULET);
   assign flags.qnz    = (dq != 17'd0);
   assign flags.dlast  = (dcnt_ff == 3'd1);
   assign flags.rbig   = (v_ff > plcg_pkg::ROMAN_MAX);
   assign flags.rlast  = rsub && (v_ff == rval);
   assign flags.llong  = (rep_ff >= 13'(plcg_pkg::MAX_LETTER_REPEATS));
   assign flags.llast  = (rep_ff == 13'd0);

   // ---------------------------------------------------------------------
   // Beat selection and handshake
   // ---------------------------------------------------------------------
   logic       emit;
   logic       emit_go;
   logic [6:0] emit_char;
   logic       emit_last;
   logic [1:0] emit_status;
   logic       step_go;

   always_comb begin
      emit        = 1'b0;
      emit_char   = 7'd0;
      emit_last   = 1'b0;
      emit_status = plcg_pkg::ST_OK;
      case (ctrl.op)
         plcg_pkg::OP_DEMIT: begin
            emit      = 1'b1;
            emit_char = plcg_pkg::CHAR_ZERO + {3'b000, dstack_ff[dtop]};
            emit_last = flags.dlast;
         end
         plcg_pkg::OP_RSCAN: begin
            emit      = rge;
            emit_char = rchar;
            emit_last = flags.rlast;
         end
         plcg_pkg::OP_LEMIT: begin
            emit      = 1'b1;
            emit_char = lbase + {2'b00, letter_ff};
            emit_last = flags.llast;
         end
         plcg_pkg::OP_EMPTY: begin
            emit        = 1'b1;
            emit_last   = 1'b1;
            emit_status = st_ff;
         end
         default: ;
      endcase
   end

   // Hold the step on a missing offset or a full output register
   assign hold    = ((ctrl.op == plcg_pkg::OP_ACCEPT) && !req_valid) || (emit && !out_free);
   assign step_go = !hold;
   assign emit_go = emit && out_free;

   assign req_stall = (ctrl.op != plcg_pkg::OP_ACCEPT);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= 3'd0;
         ri_ff        <= 4'd0;
         phase_ff     <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step_go) begin
            case (ctrl.op)
               plcg_pkg::OP_LOAD: dcnt_ff <= 3'd0;
               plcg_pkg::OP_DDIV: dcnt_ff <= dcnt_ff + 3'd1;
               plcg_pkg::OP_DEMIT: dcnt_ff <= dtop;
               plcg_pkg::OP_RCHK: begin
                  ri_ff    <= 4'd0;
                  phase_ff <= 1'b0;
               end
               plcg_pkg::OP_RSCAN: begin
                  if (!rge) begin
                     ri_ff <= ri_ff + 4'd1;
                  end else begin
                     phase_ff <= !rsub;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_char_ff   <= emit_char;
         rsp_last_ff   <= emit_last;
         rsp_status_ff <= emit_status;
      end
      if (step_go) begin
         case (ctrl.op)
            plcg_pkg::OP_ACCEPT: off_ff <= req_page_offset;
            plcg_pkg::OP_LOAD: begin
               v_ff  <= {1'b0, start_ff} + {1'b0, off_ff};
               st_ff <= plcg_pkg::ST_PAGE_OOR;
            end
            plcg_pkg::OP_DDIV: begin
               dstack_ff[dcnt_ff] <= drem[3:0];
               v_ff               <= dq;
            end
            plcg_pkg::OP_RCHK: st_ff <= plcg_pkg::ST_ROMAN_OOR;
            plcg_pkg::OP_RSCAN: begin
               if (rsub) begin
                  v_ff <= v_ff - rval;
               end
            end
            plcg_pkg::OP_LDEC: v_ff <= v_ff - 17'd1;
            plcg_pkg::OP_LMUL: rep_ff <= prod26[33:21];
            plcg_pkg::OP_LCHK: begin
               letter_ff <= lrem[4:0];
               st_ff     <= plcg_pkg::ST_LET_LONG;
            end
            plcg_pkg::OP_LEMIT: rep_ff <= rep_ff - 13'd1;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_code    = rsp_char_ff;
   assign rsp_last_char    = rsp_last_ff;
   assign rsp_label_status = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `PLCG_ASSERT_NEXT(a_last_returns_idle, clock, reset, emit_go && emit_last, ctrl.step == plcg_pkg::S_IDLE)
   `PLCG_ASSERT_IMPLY(a_empty_beat_form, clock, reset, rsp_valid_ff && (rsp_status_ff != plcg_pkg::ST_OK), (rsp_char_ff == 7'd0) && rsp_last_ff)
   `PLCG_ASSERT_IMPLY(a_digit_depth, clock, reset, ctrl.op == plcg_pkg::OP_DDIV, dcnt_ff < 3'd6)
   `PLCG_ASSERT_IMPLY(a_letter_bound, clock, reset, ctrl.op == plcg_pkg::OP_LEMIT, rep_ff < 13'(plcg_pkg::MAX_LETTER_REPEATS))

endmodule

// ===== tb/page_label_checker.sv =====
// ----------------------------------------------------------------------------
// page_label_checker
// Predicts and checks the character beats of the page label generator.
// ----------------------------------------------------------------------------
// Follows register writes on the configuration port, expands every accepted
// page offset into the label beats it must produce and compares each result
// beat, in order, against the oldest one still owed.
// ----------------------------------------------------------------------------
module page_label_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_page_offset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_char_code,
   input  logic        rsp_last_char,
   input  logic [1:0]  rsp_label_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          beats_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ALPHABET     = 26;
   localparam int REPORT_LIMIT = 100;

   localparam int NUMERAL_WEIGHT [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
   localparam logic [7:0] NUMERAL_HEAD [13] =
      '{"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"};
   localparam logic [7:0] NUMERAL_TAIL [13] =
      '{8'h00, "M", 8'h00, "D", 8'h00, "C", 8'h00, "L", 8'h00, "X", 8'h00, "V", 8'h00};

   typedef struct packed {
      logic [6:0] code;
      logic       last;
      logic [1:0] status;
   } label_beat_type;

   label_beat_type label_beats [$];

   logic [15:0] first_value;
   logic [2:0]  style_sel;
   logic [15:0] page_total;

   // Append the beats that one page offset must produce.
   function automatic void expand_label(input logic [15:0] offset);
      int         value;
      int         rest;
      int         reps;
      logic [7:0] case_bit;
      logic [7:0] text [$];
      if (offset >= page_total || first_value == 16'd0) begin
         label_beats.push_back({7'd0, 1'b1, plcg_pkg::ST_PAGE_OOR});
         return;
      end
      value = int'(first_value) + int'(offset);
      case (style_sel)
         plcg_pkg::STYLE_LROMAN, plcg_pkg::STYLE_UROMAN: begin
            if (value > int'(plcg_pkg::ROMAN_MAX)) begin
               label_beats.push_back({7'd0, 1'b1, plcg_pkg::ST_ROMAN_OOR});
               return;
            end
            case_bit = (style_sel == plcg_pkg::STYLE_LROMAN) ? 8'h20 : 8'h00;
            rest = value;
            for (int i = 0; i < 13; i++) begin
               while (rest >= NUMERAL_WEIGHT[i]) begin
                  text.push_back(NUMERAL_HEAD[i] | case_bit);
                  if (NUMERAL_TAIL[i] != 8'h00) begin
                     text.push_back(NUMERAL_TAIL[i] | case_bit);
                  end
                  rest -= NUMERAL_WEIGHT[i];
               end
            end
         end
         plcg_pkg::STYLE_LLET, plcg_pkg::STYLE_ULET: begin
            reps = (value - 1) / ALPHABET + 1;
            if (reps > plcg_pkg::MAX_LETTER_REPEATS) begin
               label_beats.push_back({7'd0, 1'b1, plcg_pkg::ST_LET_LONG});
               return;
            end
            repeat (reps) begin
               text.push_back(8'(((style_sel == plcg_pkg::STYLE_LLET) ? "a" : "A")
                                 + (value - 1) % ALPHABET));
            end
         end
         default: begin
            // unused style codes fall back to decimal
            rest = value;
            do begin
               text.push_front(8'("0" + rest % 10));
               rest /= 10;
            end while (rest != 0);
         end
      endcase
      foreach (text[k]) begin
         label_beats.push_back({text[k][6:0], k == text.size() - 1, plcg_pkg::ST_OK});
      end
   endfunction

   always @(posedge clock) begin
      label_beat_type want;
      if (reset) begin
         first_value = 16'd1;
         style_sel   = plcg_pkg::STYLE_DEC;
         page_total  = 16'd0;
         label_beats.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               plcg_pkg::REG_START: first_value = pwdata[15:0];
               plcg_pkg::REG_STYLE: style_sel   = pwdata[2:0];
               plcg_pkg::REG_COUNT: page_total  = pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expand_label(req_page_offset);
         end
         if (rsp_valid && !rsp_stall) begin
            if (label_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: unexpected beat: expected none, got char %h last %b status %0d",
                           $time, rsp_char_code, rsp_last_char, rsp_label_status);
               end
            end else begin
               want = label_beats.pop_front();
               if (want != {rsp_char_code, rsp_last_char, rsp_label_status}) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: beat mismatch: expected char %h last %b status %0d, got char %h last %b status %0d",
                              $time, want.code, want.last, want.status,
                              rsp_char_code, rsp_last_char, rsp_label_status);
                  end
               end
            end
         end
      end
      beats_due = label_beats.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the page label character generator.
// ----------------------------------------------------------------------------
// Programs the label registers over the APB-style port, feeds page offsets in
// random bursts and holds off the character channel on a pattern of its own.
// A directed pass covers the range limits of every style; random phases then
// sweep start value, style and page count. A checker beside the block predicts
// and compares every beat and hands back its mismatch count.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TOTAL_PAGES     = 430;
   localparam int          SETTLE_CYCLES   = 20;      // longer than any empty label
   localparam int          DRAIN_LIMIT     = 40000;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          TIMEOUT_NS      = 10_000_000;
   localparam logic [2:0]  STYLE_SPARE_LO  = 3'd5;     // undefined codes, read as decimal
   localparam logic [2:0]  STYLE_SPARE_HI  = 3'd7;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [15:0] req_page_offset  = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [6:0]  rsp_char_code;
   logic        rsp_last_char;
   logic [1:0]  rsp_label_status;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [3:0]  paddr            = 4'd0;
   logic [31:0] pwdata           = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int check_errors;
   int beats_due;
   int offered         = 0;
   int burst_left      = 0;
   int hold_off_asks   = 0;   // bumped by the stimulus
   int hold_off_served = 0;   // advanced by the receiver

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_label_char_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_page_offset  (req_page_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_last_char    (rsp_last_char),
      .rsp_label_status (rsp_label_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   page_label_checker label_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_page_offset  (req_page_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_last_char    (rsp_last_char),
      .rsp_label_status (rsp_label_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .mismatches       (check_errors),
      .beats_due        (beats_due)
   );

   // Write one register: setup phase, access phase until pready, then an idle wait so the
   // next transfer never lands in the same time step as this release.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every owed beat, then let the sequencer settle.
   task automatic labels_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_due != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram the label range; only ever done with the block idle.
   task automatic setup_labels(input logic [15:0] first, input logic [2:0] style,
                               input logic [15:0] total);
      labels_idle();
      write_reg(plcg_pkg::REG_START, {16'd0, first});
      write_reg(plcg_pkg::REG_STYLE, {29'd0, style});
      write_reg(plcg_pkg::REG_COUNT, {16'd0, total});
   endtask

   // Offer one offset and hold it until taken; between bursts drop valid for
   // a random gap. Returns at the edge that accepted the offset, or after the gap.
   task automatic offer_page(input logic [15:0] offset);
      req_valid       <= 1'b1;
      req_page_offset <= offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      offered++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 25) : $urandom_range(1, 6))
            @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      end
   endtask

   // Receiver pacing: stretches of free flow, light and heavy stalling and
   // toggling, plus a long hold-off whenever the stimulus asks for one.
   initial begin : rsp_pacing
      int mode;
      int stretch;
      @(posedge clock);
      forever begin
         if (hold_off_asks != hold_off_served) begin
            hold_off_served = hold_off_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(5, 60);
         repeat (stretch) begin
            if (hold_off_asks != hold_off_served) break;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= !rsp_stall;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          span;
      int          reach;
      logic [15:0] first;
      logic [15:0] total;
      logic [2:0]  style;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: page count zero puts every offset out of range.
      offer_page(16'd0);
      offer_page(16'hFFFF);

      // Zero start value leaves no valid range even with a full page count.
      setup_labels(16'd0, plcg_pkg::STYLE_DEC, 16'hFFFF);
      offer_page(16'd5);

      // Decimal at the top of the value range: six digits, then past the end.
      setup_labels(16'hFFFF, plcg_pkg::STYLE_DEC, 16'hFFFF);
      offer_page(16'd0);
      offer_page(16'hFFFE);
      offer_page(16'hFFFF);

      // Lower roman: I, the longest numeral, a mixed one, 3999 and 4000.
      setup_labels(16'd1, plcg_pkg::STYLE_LROMAN, 16'd4000);
      offer_page(16'd0);
      offer_page(16'd3887);
      offer_page(16'd1943);
      offer_page(16'd3998);
      offer_page(16'd3999);

      setup_labels(16'd1, plcg_pkg::STYLE_UROMAN, 16'd4000);
      offer_page(16'd3887);
      offer_page(16'd3999);

      // Letters: a, z, aa, the longest legal run and one past it.
      setup_labels(16'd1, plcg_pkg::STYLE_LLET, 16'd2000);
      offer_page(16'd0);
      offer_page(16'd25);
      offer_page(16'd26);
      offer_page(16'd1663);
      offer_page(16'd1664);

      setup_labels(16'd1, plcg_pkg::STYLE_ULET, 16'd2000);
      offer_page(16'd25);
      offer_page(16'd1663);
      offer_page(16'd1664);

      // Undefined style codes read as decimal.
      setup_labels(16'd9, STYLE_SPARE_HI, 16'd100);
      offer_page(16'd0);
      offer_page(16'd1);
      setup_labels(16'd99, STYLE_SPARE_LO, 16'd10);
      offer_page(16'd1);

      // Random phases: new range and style each time, offsets mostly inside it.
      phase = 0;
      while (offered < TOTAL_PAGES) begin
         style = ($urandom_range(0, 99) < 8)
                 ? 3'($urandom_range(STYLE_SPARE_LO, STYLE_SPARE_HI))
                 : 3'($urandom_range(plcg_pkg::STYLE_DEC, plcg_pkg::STYLE_ULET));
         case ($urandom_range(0, 19))
            0:       first = 16'd0;
            1, 2:    first = 16'd1;
            3:       first = 16'hFFFF;
            default: begin
               if (style == plcg_pkg::STYLE_LROMAN || style == plcg_pkg::STYLE_UROMAN) begin
                  first = 16'($urandom_range(1, 3999));
               end else if (style == plcg_pkg::STYLE_LLET || style == plcg_pkg::STYLE_ULET) begin
                  first = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 1700))
                                                      : 16'($urandom_range(1, 300));
               end else begin
                  first = 16'($urandom_range(1, 65535));
               end
            end
         endcase
         case ($urandom_range(0, 9))
            0:       total = 16'd0;
            1:       total = 16'hFFFF;
            default: total = 16'($urandom_range(1, 65535));
         endcase
         // keep roman values mostly legal and letter runs mostly short
         if (style == plcg_pkg::STYLE_LROMAN || style == plcg_pkg::STYLE_UROMAN) begin
            span = (first <= 16'd3999) ? 4008 - int'(first) : 16;
         end else if (style == plcg_pkg::STYLE_LLET || style == plcg_pkg::STYLE_ULET) begin
            span = 320;
         end else begin
            span = 65536;
         end
         reach = (int'(total) < span) ? int'(total) : span;

         setup_labels(first, style, total);
         // fill the block against a long receiver hold-off twice in the run
         if (phase == 0 || phase == 9) begin
            hold_off_asks++;
         end
         repeat ($urandom_range(6, 30)) begin
            if (reach > 0 && $urandom_range(0, 99) < 85) begin
               offer_page(16'($urandom_range(0, reach - 1)));
            end else begin
               offer_page(16'($urandom_range(0, 65535)));
            end
         end
         phase++;
      end

      labels_idle();
      if (check_errors == 0 && beats_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/plcg_pkg.sv
hdl/plcg_seq.sv
hdl/page_label_char_generator.sv
tb/page_label_checker.sv
tb/testbench.sv
